### rtl/assert_macros.svh
// assertion macros for the checker file sctd_props.sv
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every rising edge, ignored while reset is held
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// property checked at every rising edge, reset included
`define ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/sctd_pkg.sv
// constants and helper functions for the seconds to calendar date pipeline
// no dependencies
package sctd_pkg;

    // inputs at or past 2041-01-01 00:00 are flagged
    localparam logic [32:0] LIMIT_SECONDS = 33'd4449600000;

    // seconds per day is 2^7 * 675, the 675 part goes through a reciprocal
    localparam int          DAY_SHIFT  = 36;
    localparam logic [9:0]  DAY_UNITS  = 10'd675;
    localparam logic [26:0] DAY_RECIP  = 27'(((64'd1 << DAY_SHIFT) + 64'd674) / 64'd675);

    // alfa is 14 before 1900-03-01 and 15 or 16 after, alfa - alfa/4 is 11 or 12
    localparam logic [16:0] ALFA_STEP_DAYS =
        17'(((15 * 146097 + 7468865 + 3) / 4) - 2415021);
    localparam logic [21:0] B_BASE     = 22'(2415021 + 1525 + 11);
    localparam logic [25:0] N_BASE     = 26'(20 * (2415021 + 1525 + 11) - 2442);
    localparam logic [25:0] N_STEP     = 26'd20;

    // year count from the scaled B value, divided by 7305
    localparam int          C_SHIFT    = 39;
    localparam logic [26:0] C_RECIP    = 27'(((64'd1 << C_SHIFT) + 64'd7304) / 64'd7305);
    localparam logic [10:0] DAYS_PER_4Y = 11'd1461;

    localparam logic [13:0] YEAR_MARCH  = 14'd6616;
    localparam logic [13:0] YEAR_JANFEB = 14'd6615;
    localparam logic [3:0]  MONTH_FEB   = 4'd1;
    localparam logic [3:0]  E_WRAP      = 4'd14;
    localparam logic [3:0]  E_MARCH     = 4'd2;

    // time of day split by sixty, twice
    localparam int          MIN_SHIFT  = 23;
    localparam logic [17:0] MIN_RECIP  = 18'(((64'd1 << MIN_SHIFT) + 64'd59) / 64'd60);
    localparam int          HOUR_SHIFT = 17;
    localparam logic [11:0] HOUR_RECIP = 12'(((64'd1 << HOUR_SHIFT) + 64'd59) / 64'd60);
    localparam logic [5:0]  SIXTY      = 6'd60;

    // smallest B - D that reaches month count k: ceil(30.6001 * k)
    function automatic logic [8:0] month_threshold(input logic [3:0] k);
        logic [8:0] t;
        case (k)
            4'd1:    t = 9'd31;
            4'd2:    t = 9'd62;
            4'd3:    t = 9'd92;
            4'd4:    t = 9'd123;
            4'd5:    t = 9'd154;
            4'd6:    t = 9'd184;
            4'd7:    t = 9'd215;
            4'd8:    t = 9'd245;
            4'd9:    t = 9'd276;
            4'd10:   t = 9'd307;
            4'd11:   t = 9'd337;
            4'd12:   t = 9'd368;
            4'd13:   t = 9'd398;
            4'd14:   t = 9'd429;
            4'd15:   t = 9'd460;
            default: t = 9'd0;
        endcase
        return t;
    endfunction

    // month count E: number of thresholds met
    function automatic logic [3:0] calc_e(input logic [8:0] bd);
        logic [3:0] e;
        e = 4'd0;
        for (int k = 1; k < 16; k++) begin
            if (bd >= month_threshold(4'(k))) begin
                e = e + 4'd1;
            end
        end
        return e;
    endfunction

    // floor(30.6001 * e)
    function automatic logic [8:0] march_days(input logic [3:0] e);
        logic [8:0] d;
        case (e)
            4'd0:    d = 9'd0;
            4'd1:    d = 9'd30;
            4'd2:    d = 9'd61;
            4'd3:    d = 9'd91;
            4'd4:    d = 9'd122;
            4'd5:    d = 9'd153;
            4'd6:    d = 9'd183;
            4'd7:    d = 9'd214;
            4'd8:    d = 9'd244;
            4'd9:    d = 9'd275;
            4'd10:   d = 9'd306;
            4'd11:   d = 9'd336;
            4'd12:   d = 9'd367;
            4'd13:   d = 9'd397;
            4'd14:   d = 9'd428;
            4'd15:   d = 9'd459;
            default: d = 9'd0;
        endcase
        return d;
    endfunction

    // gregorian rule on year + 1900 for the 8-bit year range
    function automatic logic is_leap(input logic [7:0] year);
        return (year[1:0] == 2'd0) && (year != 8'd0) && (year != 8'd200);
    endfunction

    // day of year of the first of the month
    function automatic logic [8:0] first_day(input logic leap, input logic [3:0] mon);
        logic [8:0] d;
        case (mon)
            4'd0:    d = 9'd0;
            4'd1:    d = 9'd31;
            4'd2:    d = 9'd59;
            4'd3:    d = 9'd90;
            4'd4:    d = 9'd120;
            4'd5:    d = 9'd151;
            4'd6:    d = 9'd181;
            4'd7:    d = 9'd212;
            4'd8:    d = 9'd243;
            4'd9:    d = 9'd273;
            4'd10:   d = 9'd304;
            4'd11:   d = 9'd334;
            default: d = 9'd0;
        endcase
        if (leap && (mon > MONTH_FEB)) begin
            d = d + 9'd1;
        end
        return d;
    endfunction

endpackage

### rtl/sctd_tod.sv
// time of day pipeline: seconds of day into hour, minute and second
// four register stages sharing the top level's stall enable; uses sctd_pkg
module sctd_tod (
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [16:0] i_tod,
    output logic [4:0]  o_hour,
    output logic [5:0]  o_minute,
    output logic [5:0]  o_second
);
    import sctd_pkg::*;

    logic [34:0] r_mprod;
    logic [16:0] r_tod;
    logic [10:0] r_mtot;
    logic [5:0]  r_sec;
    logic [22:0] r_hprod;
    logic [10:0] r_mtot_d;
    logic [5:0]  r_sec_d;
    logic [4:0]  r_hour;
    logic [5:0]  r_minute;
    logic [5:0]  r_second;

    logic [34:0] n_mprod;
    logic [10:0] n_mtot;
    logic [5:0]  n_sec;
    logic [22:0] n_hprod;
    logic [4:0]  n_hour;
    logic [5:0]  n_minute;

    always_comb begin
        n_mprod  = 35'(i_tod) * 35'(MIN_RECIP);
        n_mtot   = r_mprod[MIN_SHIFT +: 11];
        n_sec    = 6'(r_tod - (17'(n_mtot) * 17'(SIXTY)));
        n_hprod  = 23'(r_mtot) * 23'(HOUR_RECIP);
        n_hour   = r_hprod[HOUR_SHIFT +: 5];
        n_minute = 6'(r_mtot_d - (11'(n_hour) * 11'(SIXTY)));
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_mprod  <= n_mprod;
            r_tod    <= i_tod;
            r_mtot   <= n_mtot;
            r_sec    <= n_sec;
            r_hprod  <= n_hprod;
            r_mtot_d <= r_mtot;
            r_sec_d  <= r_sec;
            r_hour   <= n_hour;
            r_minute <= n_minute;
            r_second <= r_sec_d;
        end
    end

    assign o_hour   = r_hour;
    assign o_minute = r_minute;
    assign o_second = r_second;

endmodule

### rtl/seconds_to_calendar_date.sv
// seconds since 1900 into calendar date and time of day, eight stage pipeline
// uses sctd_pkg and sctd_tod
//
//   channel | valid   | ready   | payload
//   --------+---------+---------+-------------------------------------------
//   input   | i_valid | o_ready | i_seconds_since_1900
//   output  | o_valid | i_ready | o_year_since_1900 .. o_out_of_range
//
// one transaction per cycle while the output is not stalled
// the stages follow the chain of reciprocal multiplies for days and year count,
// then the month count compare and the day of year lookup, each with a register
// the whole pipe advances together; a stalled output freezes every stage
// synchronous reset clears only the stage valid bits
module seconds_to_calendar_date (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [32:0] i_seconds_since_1900,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [7:0]  o_year_since_1900,
    output logic [3:0]  o_month_index,
    output logic [4:0]  o_day_of_month,
    output logic [4:0]  o_hour_of_day,
    output logic [5:0]  o_minute_of_hour,
    output logic [5:0]  o_second_of_minute,
    output logic [8:0]  o_day_of_year,
    output logic        o_out_of_range
);
    import sctd_pkg::*;

    logic        en;
    logic [7:0]  r_vld;
    logic [7:0]  r_oor;

    // stage 1
    logic [52:0] r_s1_prod;
    logic [25:0] r_s1_q0;
    logic [6:0]  r_s1_lo;
    // stage 2
    logic [16:0] r_s2_days;
    logic [16:0] r_s2_tod;
    // stage 3
    logic [21:0] r_s3_b;
    logic [25:0] r_s3_n;
    // stage 4
    logic [52:0] r_s4_cprod;
    logic [21:0] r_s4_b;
    // stage 5
    logic [13:0] r_s5_c;
    logic [8:0]  r_s5_bd;
    // stage 6
    logic [3:0]  r_s6_e;
    logic [13:0] r_s6_c;
    logic [8:0]  r_s6_bd;
    // stage 7
    logic [7:0]  r_s7_year;
    logic [3:0]  r_s7_mon;
    logic [4:0]  r_s7_mday;
    logic [4:0]  r_s7_hour;
    logic [5:0]  r_s7_minute;
    logic [5:0]  r_s7_second;
    // stage 8, output register
    logic [7:0]  r_year;
    logic [3:0]  r_mon;
    logic [4:0]  r_mday;
    logic [4:0]  r_hour;
    logic [5:0]  r_minute;
    logic [5:0]  r_second;
    logic [8:0]  r_yday;

    logic [52:0] n_s1_prod;
    logic [16:0] n_s2_days;
    logic [25:0] n_s2_rem;
    logic        s3_step;
    logic [21:0] n_s3_b;
    logic [25:0] n_s3_n;
    logic [52:0] n_s4_cprod;
    logic [13:0] n_s5_c;
    logic [24:0] s5_cd;
    logic [8:0]  n_s5_bd;
    logic [3:0]  n_s7_mon;
    logic [4:0]  n_s7_mday;
    logic [7:0]  n_s7_year;
    logic [8:0]  n_yday;

    logic [4:0]  tod_hour;
    logic [5:0]  tod_minute;
    logic [5:0]  tod_second;

    assign en      = !r_vld[7] || i_ready;
    assign o_ready = en;

    always_comb begin
        n_s1_prod  = 53'(i_seconds_since_1900[32:7]) * 53'(DAY_RECIP);

        n_s2_days  = r_s1_prod[DAY_SHIFT +: 17];
        n_s2_rem   = r_s1_q0 - 26'(27'(n_s2_days) * 27'(DAY_UNITS));

        s3_step    = (r_s2_days >= ALFA_STEP_DAYS);
        n_s3_b     = B_BASE + 22'(r_s2_days) + 22'(s3_step);
        n_s3_n     = N_BASE + 26'(26'(r_s2_days) * N_STEP) + (s3_step ? N_STEP : 26'd0);

        n_s4_cprod = 53'(r_s3_n) * 53'(C_RECIP);

        n_s5_c     = r_s4_cprod[C_SHIFT +: 14];
        s5_cd      = 25'(n_s5_c) * 25'(DAYS_PER_4Y);
        // only the low bits of B - D matter, the difference stays below 512
        n_s5_bd    = r_s4_b[8:0] - s5_cd[10:2];

        n_s7_mday  = 5'(r_s6_bd - march_days(r_s6_e));
        n_s7_mon   = (r_s6_e < E_WRAP) ? (r_s6_e - E_MARCH) : (r_s6_e - E_WRAP);
        n_s7_year  = 8'(r_s6_c - ((n_s7_mon > MONTH_FEB) ? YEAR_MARCH : YEAR_JANFEB));

        n_yday     = first_day(is_leap(r_s7_year), r_s7_mon) + 9'(r_s7_mday) - 9'd1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[6:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_oor       <= {r_oor[6:0], (i_seconds_since_1900 >= LIMIT_SECONDS)};

            r_s1_prod   <= n_s1_prod;
            r_s1_q0     <= i_seconds_since_1900[32:7];
            r_s1_lo     <= i_seconds_since_1900[6:0];

            r_s2_days   <= n_s2_days;
            r_s2_tod    <= {n_s2_rem[9:0], r_s1_lo};

            r_s3_b      <= n_s3_b;
            r_s3_n      <= n_s3_n;

            r_s4_cprod  <= n_s4_cprod;
            r_s4_b      <= r_s3_b;

            r_s5_c      <= n_s5_c;
            r_s5_bd     <= n_s5_bd;

            r_s6_e      <= calc_e(r_s5_bd);
            r_s6_c      <= r_s5_c;
            r_s6_bd     <= r_s5_bd;

            r_s7_year   <= n_s7_year;
            r_s7_mon    <= n_s7_mon;
            r_s7_mday   <= n_s7_mday;
            r_s7_hour   <= tod_hour;
            r_s7_minute <= tod_minute;
            r_s7_second <= tod_second;

            // out of range results carry zeros in every other field
            if (r_oor[6]) begin
                r_year   <= '0;
                r_mon    <= '0;
                r_mday   <= '0;
                r_hour   <= '0;
                r_minute <= '0;
                r_second <= '0;
                r_yday   <= '0;
            end else begin
                r_year   <= r_s7_year;
                r_mon    <= r_s7_mon;
                r_mday   <= r_s7_mday;
                r_hour   <= r_s7_hour;
                r_minute <= r_s7_minute;
                r_second <= r_s7_second;
                r_yday   <= n_yday;
            end
        end
    end

    sctd_tod u_tod (
        .i_clk    (i_clk),
        .i_en     (en),
        .i_tod    (r_s2_tod),
        .o_hour   (tod_hour),
        .o_minute (tod_minute),
        .o_second (tod_second)
    );

    assign o_valid            = r_vld[7];
    assign o_year_since_1900  = r_year;
    assign o_month_index      = r_mon;
    assign o_day_of_month     = r_mday;
    assign o_hour_of_day      = r_hour;
    assign o_minute_of_hour   = r_minute;
    assign o_second_of_minute = r_second;
    assign o_day_of_year      = r_yday;
    assign o_out_of_range     = r_oor[7];

endmodule

### rtl/sctd_props.sv
// port level checks for seconds_to_calendar_date, bound to the top level
// depends on assert_macros.svh
`include "assert_macros.svh"

module sctd_props (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_ready,
    input logic [32:0] i_seconds_since_1900,
    input logic        o_valid,
    input logic        i_ready,
    input logic [7:0]  o_year_since_1900,
    input logic [3:0]  o_month_index,
    input logic [4:0]  o_day_of_month,
    input logic [4:0]  o_hour_of_day,
    input logic [5:0]  o_minute_of_hour,
    input logic [5:0]  o_second_of_minute,
    input logic [8:0]  o_day_of_year,
    input logic        o_out_of_range
);

    // no result shows right after reset
    `ASSERT_ALWAYS(a_reset_empty, i_clk, !i_rst_n |=> !o_valid, "o_valid after reset")

    // an empty output register never blocks the input side
    `ASSERT_CLK(a_ready_when_empty, i_clk, i_rst_n, !o_valid |-> o_ready, "input blocked while output empty")

    // a stalled result stays valid and holds its day of year and second of minute
    `ASSERT_CLK(a_stall_holds, i_clk, i_rst_n, o_valid && !i_ready |=> o_valid && $stable(o_day_of_year) && $stable(o_second_of_minute), "stalled result changed")

    // out of range results carry zeros in the date fields and the hour
    `ASSERT_CLK(a_oor_zero, i_clk, i_rst_n, o_valid && o_out_of_range |-> (o_year_since_1900 == 8'd0) && (o_month_index == 4'd0) && (o_day_of_month == 5'd0) && (o_day_of_year == 9'd0) && (o_hour_of_day == 5'd0), "out of range fields not zero")

    // in range results are legal dates and times
    `ASSERT_CLK(a_fields_legal, i_clk, i_rst_n, o_valid && !o_out_of_range |-> (o_year_since_1900 <= 8'd140) && (o_month_index <= 4'd11) && (o_day_of_month != 5'd0) && (o_hour_of_day <= 5'd23) && (o_minute_of_hour <= 6'd59) && (o_second_of_minute <= 6'd59) && (o_day_of_year <= 9'd365), "field out of its range")

endmodule

bind seconds_to_calendar_date sctd_props u_sctd_props (.*);

### test/seconds_to_calendar_date_test.sv
// self-checking testbench for seconds_to_calendar_date: a behavioral calendar predictor
// feeds a scoreboard that checks every output transaction in order
// depends on sctd_pkg and seconds_to_calendar_date
module seconds_to_calendar_date_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int          PIPE_LATENCY  = 8;
    localparam int          HOLD_CYCLES   = 300;
    localparam int          RANDOM_ITEMS  = 1750;
    localparam int          CYCLE_LIMIT   = 400000;
    localparam int          DAY_SECONDS   = 86400;
    localparam int          JD_1900       = 2415021;
    localparam longint      LAST_SECONDS  = 64'd8589934591;
    localparam longint      LIMIT         = longint'(sctd_pkg::LIMIT_SECONDS);

    typedef struct packed {
        logic [7:0] year;
        logic [3:0] month;
        logic [4:0] mday;
        logic [4:0] hour;
        logic [5:0] minute;
        logic [5:0] second;
        logic [8:0] yday;
        logic       out_of_range;
    } t_date;

    typedef struct {
        logic [32:0] secs;
        t_date       date;
    } t_date_expect;

    typedef enum logic [1:0] {
        RX_ALWAYS,
        RX_COIN,
        RX_MOSTLY,
        RX_PERIODIC
    } t_rx_mode;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    logic [32:0] i_seconds_since_1900;
    logic        o_valid;
    logic        i_ready;
    logic [7:0]  o_year_since_1900;
    logic [3:0]  o_month_index;
    logic [4:0]  o_day_of_month;
    logic [4:0]  o_hour_of_day;
    logic [5:0]  o_minute_of_hour;
    logic [5:0]  o_second_of_minute;
    logic [8:0]  o_day_of_year;
    logic        o_out_of_range;

    // acceptance flags, sampled at the falling edge before the accepting rising edge
    bit in_fire;
    bit out_fire;
    bit hold_output;
    int cycle_count;

    function automatic bit is_leap_year(input int full_year);
        return ((full_year % 4 == 0) && (full_year % 100 != 0)) || (full_year % 400 == 0);
    endfunction

    function automatic int month_length(input int year_since_1900, input int mon);
        int lengths [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
        if (mon == 1 && is_leap_year(year_since_1900 + 1900)) begin
            return 29;
        end
        return lengths[mon];
    endfunction

    // days from 1900-01-01 to the first of the given month
    function automatic int day_number(input int year_since_1900, input int mon);
        int days;
        days = 0;
        for (int y = 0; y < year_since_1900; y++) begin
            days += is_leap_year(y + 1900) ? 366 : 365;
        end
        for (int m = 0; m < mon; m++) begin
            days += month_length(year_since_1900, m);
        end
        return days;
    endfunction

    class calendar_scoreboard;
        t_date_expect pending_dates[$];
        int           mismatches;

        function t_date predict_date(input logic [32:0] secs);
            longint unsigned s, tod, z, alfa, b, c, d, e, mday, mon, yr, yday;
            t_date r;
            r = '0;
            s = secs;
            if (s >= LIMIT) begin
                r.out_of_range = 1'b1;
                return r;
            end
            tod  = s % DAY_SECONDS;
            z    = s / DAY_SECONDS + JD_1900;
            alfa = (4 * z - 7468865) / 146097;
            b    = z + alfa - alfa / 4 + 1525;
            c    = (20 * b - 2442) / 7305;
            d    = (1461 * c) / 4;
            e    = (10000 * (b - d)) / 306001;
            mday = b - d - (306001 * e) / 10000;
            mon  = (e < 14) ? e - 2 : e - 14;
            yr   = (mon > 1) ? c - 6616 : c - 6615;
            yday = mday - 1;
            for (int m = 0; m < int'(mon); m++) begin
                yday += month_length(int'(yr), m);
            end
            r.year   = 8'(yr);
            r.month  = 4'(mon);
            r.mday   = 5'(mday);
            r.hour   = 5'(tod / 3600);
            r.minute = 6'((tod % 3600) / 60);
            r.second = 6'(tod % 60);
            r.yday   = 9'(yday);
            return r;
        endfunction

        function void note_timestamp(input logic [32:0] secs);
            t_date_expect x;
            x.secs = secs;
            x.date = predict_date(secs);
            pending_dates.push_back(x);
        endfunction

        function void compare_field(input string name, input logic [32:0] secs,
                                    input int unsigned want, input int unsigned got);
            if (want != got) begin
                $display("%0t: %s mismatch for seconds %0d, expected %0d, actual %0d",
                         $realtime, name, secs, want, got);
                mismatches++;
            end
        endfunction

        function void check_date(input t_date got);
            t_date_expect x;
            if (pending_dates.size() == 0) begin
                $display("%0t: unexpected result transaction, expected none, actual %h",
                         $realtime, got);
                mismatches++;
                return;
            end
            x = pending_dates.pop_front();
            compare_field("year_since_1900", x.secs, x.date.year, got.year);
            compare_field("month_index", x.secs, x.date.month, got.month);
            compare_field("day_of_month", x.secs, x.date.mday, got.mday);
            compare_field("hour_of_day", x.secs, x.date.hour, got.hour);
            compare_field("minute_of_hour", x.secs, x.date.minute, got.minute);
            compare_field("second_of_minute", x.secs, x.date.second, got.second);
            compare_field("day_of_year", x.secs, x.date.yday, got.yday);
            compare_field("out_of_range", x.secs, x.date.out_of_range, got.out_of_range);
        endfunction
    endclass

    calendar_scoreboard dates = new();

    seconds_to_calendar_date dut (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_valid              (i_valid),
        .o_ready              (o_ready),
        .i_seconds_since_1900 (i_seconds_since_1900),
        .o_valid              (o_valid),
        .i_ready              (i_ready),
        .o_year_since_1900    (o_year_since_1900),
        .o_month_index        (o_month_index),
        .o_day_of_month       (o_day_of_month),
        .o_hour_of_day        (o_hour_of_day),
        .o_minute_of_hour     (o_minute_of_hour),
        .o_second_of_minute   (o_second_of_minute),
        .o_day_of_year        (o_day_of_year),
        .o_out_of_range       (o_out_of_range)
    );

    always #2 i_clk = ~i_clk;

    // everything is stable here, half a cycle away from any drive
    always @(negedge i_clk) begin
        in_fire  = i_rst_n && i_valid && o_ready;
        out_fire = i_rst_n && o_valid && i_ready;
        if (in_fire) begin
            dates.note_timestamp(i_seconds_since_1900);
        end
        if (out_fire) begin
            dates.check_date({o_year_since_1900, o_month_index, o_day_of_month,
                              o_hour_of_day, o_minute_of_hour, o_second_of_minute,
                              o_day_of_year, o_out_of_range});
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // receiver: random stretches of stall patterns, plus a long hold on request
    initial begin
        t_rx_mode mode;
        int       len;
        i_ready <= 1'b0;
        forever begin
            if (hold_output) begin
                hold_output = 1'b0;
                i_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end
            mode = t_rx_mode'($urandom_range(0, 3));
            len  = $urandom_range(4, 64);
            while (len > 0 && !hold_output) begin
                case (mode)
                    RX_ALWAYS:   i_ready <= 1'b1;
                    RX_COIN:     i_ready <= 1'($urandom_range(0, 1));
                    RX_MOSTLY:   i_ready <= ($urandom_range(0, 3) != 0);
                    RX_PERIODIC: i_ready <= (len % 4 != 0);
                    default:     i_ready <= 1'b1;
                endcase
                @(posedge i_clk);
                len--;
            end
        end
    end

    task automatic offer_timestamp(input longint unsigned secs);
        i_valid              <= 1'b1;
        i_seconds_since_1900 <= 33'(secs);
        do @(posedge i_clk); while (!in_fire);
    endtask

    task automatic pause_sender(input int n);
        if (n > 0) begin
            i_valid <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    task automatic wait_for_dates_drained();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (dates.pending_dates.size() != 0);
    endtask

    function automatic longint unsigned pick_timestamp();
        int              tod_edges [6] = '{0, 59, 60, 3599, 3600, 86399};
        int              pick;
        int              day;
        int              tod;
        int              offsets [7] = '{-1, 0, 1, 27, 28, 29, 30};
        pick = $urandom_range(0, 99);
        tod  = ($urandom_range(0, 2) == 0) ? tod_edges[$urandom_range(0, 5)]
                                           : $urandom_range(0, DAY_SECONDS - 1);
        if (pick < 45) begin
            day = $urandom_range(0, 51499);
            return longint'(day) * DAY_SECONDS + $urandom_range(0, DAY_SECONDS - 1);
        end else if (pick < 65) begin
            // around the first and last days of a month
            day = day_number($urandom_range(0, 140), $urandom_range(0, 11))
                  + offsets[$urandom_range(0, 6)];
            if (day < 0) begin
                day = 0;
            end
            return longint'(day) * DAY_SECONDS + tod;
        end else if (pick < 75) begin
            return LIMIT - 200 + $urandom_range(0, 400);
        end else if (pick < 87) begin
            return LIMIT + $urandom_range(0, 32'(LAST_SECONDS - LIMIT));
        end
        return {$urandom_range(0, 1), $urandom()};
    endfunction

    initial begin
        longint unsigned corners[$];
        int              sent;
        int              burst;
        bit              held_once;
        bit              drained_once;

        i_rst_n              <= 1'b0;
        i_valid              <= 1'b0;
        i_seconds_since_1900 <= '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed corners: field extremes, century and leap days, the range limit
        corners = '{0, 1, 86399, 86400, 45296, 2678399, 2678400};
        corners.push_back(longint'(day_number(0, 2)) * DAY_SECONDS - 1);
        corners.push_back(longint'(day_number(0, 2)) * DAY_SECONDS);
        corners.push_back(longint'(day_number(1, 0)) * DAY_SECONDS - 1);
        corners.push_back(longint'(day_number(4, 1) + 28) * DAY_SECONDS);
        corners.push_back(longint'(day_number(5, 0)) * DAY_SECONDS - 1);
        corners.push_back(longint'(day_number(100, 1) + 28) * DAY_SECONDS + 43210);
        corners.push_back(longint'(day_number(101, 0)) * DAY_SECONDS - 1);
        corners.push_back(longint'(day_number(140, 1) + 28) * DAY_SECONDS);
        corners.push_back(64'd4294967295);
        corners.push_back(64'd4294967296);
        corners.push_back(LIMIT - 1);
        corners.push_back(LIMIT);
        corners.push_back(LIMIT + 1);
        corners.push_back(LAST_SECONDS);
        foreach (corners[k]) begin
            offer_timestamp(corners[k]);
            pause_sender($urandom_range(0, 1) * $urandom_range(1, 3));
        end
        wait_for_dates_drained();

        held_once    = 1'b0;
        drained_once = 1'b0;
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            if (!held_once && sent >= 600) begin
                // stall the output and keep offering so the pipe backs up
                hold_output = 1'b1;
                held_once   = 1'b1;
                repeat (48) offer_timestamp(pick_timestamp());
                sent += 48;
            end else if (!drained_once && sent >= 1200) begin
                wait_for_dates_drained();
                drained_once = 1'b1;
            end
            burst = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                                : $urandom_range(1, 24);
            repeat (burst) offer_timestamp(pick_timestamp());
            sent += burst;
            pause_sender(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12));
        end

        wait_for_dates_drained();
        repeat (PIPE_LATENCY * 4) @(posedge i_clk);
        if (dates.mismatches == 0 && dates.pending_dates.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
